// ===== src/bounded_stack_calculator_unit_macros.svh =====
// Assertion macros for the bounded stack calculator.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef BOUNDED_STACK_CALCULATOR_UNIT_MACROS_SVH
`define BOUNDED_STACK_CALCULATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bsc_pkg.sv =====
// Shared types and constants of the bounded stack calculator.
// No dependencies.
package bsc_pkg;

  localparam int unsigned ValW = 31;
  localparam int unsigned OpW  = 4;
  localparam int unsigned MagW = 62;

  localparam logic [MagW-1:0] MagLimit = 62'd1000000000;

  typedef enum logic [OpW-1:0] {
    OP_START = 4'd0,
    OP_NUM   = 4'd1,
    OP_POP   = 4'd2,
    OP_INV   = 4'd3,
    OP_DUP   = 4'd4,
    OP_SWP   = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_MUL   = 4'd8,
    OP_DIV   = 4'd9,
    OP_MOD   = 4'd10,
    OP_END   = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_MUL = 3'd2,
    ALU_DIV = 3'd3,
    ALU_MOD = 3'd4,
    ALU_INV = 3'd5
  } alu_op_e;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_rsp_t;

endpackage

// ===== src/bsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsc_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bsc_alu.sv =====
// Shared arithmetic unit: add/sub/negate, bit-serial multiply,
// restoring divide. Depends on bsc_pkg.
module bsc_alu
  import bsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  alu_op_e                op_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [ValW-1:0] b_i,
  output alu_rsp_t               rsp_o,
  output logic signed [ValW-1:0] res_o
);

  typedef enum logic [2:0] {
    AS_IDLE = 3'b001,
    AS_RUN  = 3'b010,
    AS_FIN  = 3'b100
  } alu_state_e;

  alu_state_e state_q, state_d;
  alu_op_e    op_q, op_d;
  logic [31:0]     acc_q, acc_d;
  logic [ValW-1:0] lo_q, lo_d;
  logic [ValW-1:0] dsr_q, dsr_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            sgn_q, sgn_d;

  logic [ValW-1:0] mag_a, mag_b;
  logic [31:0]     sum_s, sum_mag;
  logic [31:0]     mul_sum, div_sh;
  logic [32:0]     div_diff;
  logic            qbit;
  logic [MagW-1:0] mag;

  always_comb begin
    mag_a    = a_i[ValW-1] ? ValW'(-a_i) : a_i;
    mag_b    = b_i[ValW-1] ? ValW'(-b_i) : b_i;
    unique case (op_i)
      ALU_SUB: sum_s = {a_i[ValW-1], a_i} - {b_i[ValW-1], b_i};
      ALU_INV: sum_s = 32'd0 - {b_i[ValW-1], b_i};
      default: sum_s = {a_i[ValW-1], a_i} + {b_i[ValW-1], b_i};
    endcase
    sum_mag  = sum_s[31] ? (32'd0 - sum_s) : sum_s;
    mul_sum  = {1'b0, acc_q[ValW-1:0]} + (lo_q[0] ? {1'b0, dsr_q} : 32'd0);
    div_sh   = {acc_q[ValW-1:0], lo_q[ValW-1]};
    div_diff = {1'b0, div_sh} - {2'b00, dsr_q};
    qbit     = ~div_diff[32];
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    lo_d    = lo_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    sgn_d   = sgn_q;
    unique case (state_q)
      AS_IDLE: begin
        if (start_i) begin
          op_d  = op_i;
          cnt_d = 5'(ValW - 1);
          acc_d = '0;
          unique case (op_i)
            ALU_MUL: begin
              lo_d    = mag_b;
              dsr_d   = mag_a;
              sgn_d   = a_i[ValW-1] ^ b_i[ValW-1];
              state_d = AS_RUN;
            end
            ALU_DIV, ALU_MOD: begin
              lo_d    = mag_a;
              dsr_d   = mag_b;
              sgn_d   = (op_i == ALU_DIV) ? (a_i[ValW-1] ^ b_i[ValW-1]) : a_i[ValW-1];
              state_d = AS_RUN;
            end
            default: begin
              acc_d   = {31'd0, sum_mag[31]};
              lo_d    = sum_mag[ValW-1:0];
              sgn_d   = sum_s[31];
              state_d = AS_FIN;
            end
          endcase
        end
      end
      AS_RUN: begin
        if (op_q == ALU_MUL) begin
          acc_d = {1'b0, mul_sum[31:1]};
          lo_d  = {mul_sum[0], lo_q[ValW-1:1]};
        end else begin
          acc_d = qbit ? div_diff[31:0] : div_sh;
          lo_d  = {lo_q[ValW-2:0], qbit};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = AS_FIN;
        end
      end
      AS_FIN: begin
        state_d = AS_IDLE;
      end
      default: state_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      op_q    <= ALU_ADD;
      cnt_q   <= '0;
      sgn_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      sgn_q   <= sgn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    dsr_q <= dsr_d;
  end

  // Pick the magnitude the operation left behind.
  always_comb begin
    unique case (op_q)
      ALU_DIV: mag = {31'd0, lo_q};
      ALU_MOD: mag = {30'd0, acc_q};
      default: mag = {acc_q[ValW-1:0], lo_q};
    endcase
    rsp_o.done = (state_q == AS_FIN);
    rsp_o.ovf  = (mag > MagLimit);
    res_o      = sgn_q ? ValW'(-mag[ValW-1:0]) : mag[ValW-1:0];
  end

endmodule

// ===== src/bounded_stack_calculator_unit.sv =====
// Top level of the bounded stack calculator: sequencer, top-of-stack register,
// stack RAM and shared ALU. Depends on bsc_pkg, bsc_ram, bsc_alu, macros header.
//
// Channel  | Dir | tvalid/tready   | tdata                 | tuser
// s_axis   | in  | instruction     | [30:0] operand        | [3:0] opcode
// m_axis   | out | END result      | [30:0] value, [31] 0  | [0] error
//
// START, NUM, DUP, END and ignored items finish in the idle state; POP (from
// depth two up) and SWP add a RAM read state; the rest pass a fetch state and
// the ALU, bit-serial for MUL, DIV and MOD (31 steps); DIV or MOD by zero
// stops at fetch. The top entry sits in a register; deeper entries live in
// the RAM, whose read port is registered.
// Reset clears depth, error flag and handshake state; the RAM is not cleared.
// A waiting result does not stall input, except that END waits for the slot.
`include "bounded_stack_calculator_unit_macros.svh"

module bounded_stack_calculator_unit
  import bsc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] operand, [31] pad
  input  logic [3:0]  s_axis_tuser,   // [3:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] value, [31] pad
  output logic        m_axis_tuser    // [0] error
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POP   = 5'b00010,
    ST_SWP   = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_ALU   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic            err_q, err_d;
  logic [ValW-1:0] top_q, top_d;
  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] out_val_q, out_val_d;
  logic            out_err_q, out_err_d;

  logic            in_fire;
  op_e             opc;
  logic [ValW-1:0] imm;
  logic [DW-1:0]   dm1, dm2;
  logic            full;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ValW-1:0] ram_wdata;
  logic [ValW-1:0] ram_rdata;

  logic            alu_start;
  alu_op_e         alu_op;
  logic [ValW-1:0] alu_res;
  alu_rsp_t        alu_rsp;

  // Only END needs the result slot; hold it off while a result is still waiting.
  assign s_axis_tready = (state_q == ST_IDLE) &&
                         (opc != OP_END || !out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign opc           = op_e'(s_axis_tuser);
  assign imm           = s_axis_tdata[ValW-1:0];
  assign dm1           = depth_q - DW'(1);
  assign dm2           = depth_q - DW'(2);
  assign full          = (depth_q == DW'(STACK_DEPTH));

  // Map instruction onto ALU operation.
  always_comb begin
    unique case (op_q)
      OP_SUB:  alu_op = ALU_SUB;
      OP_MUL:  alu_op = ALU_MUL;
      OP_DIV:  alu_op = ALU_DIV;
      OP_MOD:  alu_op = ALU_MOD;
      OP_INV:  alu_op = ALU_INV;
      default: alu_op = ALU_ADD;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    depth_d     = depth_q;
    err_d       = err_q;
    top_d       = top_q;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_we      = 1'b0;
    ram_waddr   = dm1[AW-1:0];
    ram_wdata   = top_q;
    alu_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d = opc;
          if (opc == OP_START) begin
            // Restart the program: fresh stack holding the operand.
            depth_d = DW'(1);
            err_d   = 1'b0;
            top_d   = imm;
          end else if (opc == OP_END) begin
            out_valid_d = 1'b1;
            if (err_q || depth_q != DW'(1)) begin
              out_val_d = '0;
              out_err_d = 1'b1;
            end else begin
              out_val_d = top_q;
              out_err_d = 1'b0;
            end
          end else if (!err_q) begin
            case (opc)
              OP_NUM, OP_DUP: begin
                if (full || (opc == OP_DUP && depth_q == '0)) begin
                  err_d = 1'b1;
                end else begin
                  // Spill the old top into the RAM, then push.
                  ram_we  = (depth_q != '0);
                  depth_d = depth_q + DW'(1);
                  if (opc == OP_NUM) begin
                    top_d = imm;
                  end
                end
              end
              OP_POP: begin
                if (depth_q == '0) begin
                  err_d = 1'b1;
                end else begin
                  depth_d = dm1;
                  if (depth_q >= DW'(2)) begin
                    state_d = ST_POP;
                  end
                end
              end
              OP_INV: begin
                if (depth_q == '0) begin
                  err_d = 1'b1;
                end else begin
                  state_d = ST_FETCH;
                end
              end
              OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (depth_q < DW'(2)) begin
                  err_d = 1'b1;
                end else begin
                  state_d = (opc == OP_SWP) ? ST_SWP : ST_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_POP: begin
        top_d   = ram_rdata;
        state_d = ST_IDLE;
      end
      ST_SWP: begin
        ram_we    = 1'b1;
        ram_waddr = dm2[AW-1:0];
        top_d     = ram_rdata;
        state_d   = ST_IDLE;
      end
      ST_FETCH: begin
        // Second entry is on the RAM read port now.
        if ((op_q == OP_DIV || op_q == OP_MOD) && top_q == '0) begin
          err_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          alu_start = 1'b1;
          state_d   = ST_ALU;
        end
      end
      ST_ALU: begin
        if (alu_rsp.done) begin
          if (op_q != OP_INV) begin
            depth_d = dm1;
          end
          if (alu_rsp.ovf) begin
            err_d = 1'b1;
          end else begin
            top_d = alu_res;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_START;
      depth_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      depth_q     <= depth_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  bsc_ram #(
    .Width(ValW),
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(dm2[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  bsc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(alu_start),
    .op_i   (alu_op),
    .a_i    (ram_rdata),
    .b_i    (top_q),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_val_q};
  assign m_axis_tuser  = out_err_q;

  `BSC_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DW'(STACK_DEPTH), "stack depth overflow")
  `BSC_ASSERT_IMP(a_accept_idle, in_fire, state_q == ST_IDLE, "transfer taken while busy")
  `BSC_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error not 0")
  `BSC_ASSERT_NXT(a_start_init, in_fire && opc == OP_START, depth_q == DW'(1) && !err_q, "bad START")

endmodule
